/* rtl/tkce_pkg.sv */
`timescale 1ns / 1ps

package tkce_pkg;

  localparam int SCORE_BITS  = 32;
  localparam int CLASS_W     = 10;
  localparam int MAX_CLASSES = 1024;
  localparam int TOP_SLOTS   = 5;
  localparam int POS_W       = 3;
  localparam int COUNT_W     = 24;
  localparam int QDEPTH      = 3;
  localparam int QPTR_W      = 2;

  localparam logic [CLASS_W-1:0] CLASS_LAST = CLASS_W'(MAX_CLASSES - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

  localparam logic KIND_TOP1 = 1'b0;
  localparam logic KIND_TOP5 = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic [SCORE_BITS-1:0] key;
    logic [POS_W-1:0]      pos;
    logic [CLASS_W-1:0]    cls;
  } cell_t;

  typedef struct packed {
    logic               pend;
    logic               kind;
    logic [CLASS_W-1:0] label;
    logic [CLASS_W-1:0] best_class;
  } res_req_t;

  typedef struct packed {
    logic               miss;
    logic [COUNT_W-1:0] count;
  } q_word_t;

endpackage

/* rtl/tkce_ifs.sv */
`timescale 1ns / 1ps

interface tkce_in_if;
  import tkce_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [SCORE_BITS-1:0] score;
  logic        [CLASS_W-1:0]    label;
  logic                         last;
  modport source (output valid, score, label, last, input ready);
  modport sink (input valid, score, label, last, output ready);
endinterface

interface tkce_out_if;
  import tkce_pkg::*;
  logic               valid;
  logic               ready;
  logic               miss;
  logic [COUNT_W-1:0] error_count;
  logic               done_res;
  modport source (output valid, miss, error_count, done_res, input ready);
  modport sink (input valid, miss, error_count, done_res, output ready);
endinterface

interface tkce_cfg_if;
  logic valid;
  logic ready;
  logic error_kind;
  modport source (output valid, error_kind, input ready);
  modport sink (input valid, error_kind, output ready);
endinterface

/* rtl/topk_classification_error_counter.sv */
`timescale 1ns / 1ps

// Streaming top-1 / top-5 classification error counter.
// in_ch carries one class score per word (signed Q16.16) in class order,
// with the sample label and a last flag on the final score of a sample.
// out_ch returns one word per sample: miss, the saturating error count
// including this sample, and done_res = 1.
// cfg_ch writes error_kind (0 top-1, 1 top-5); write only while idle.
// Throughput: one input word per cycle while the result queue has room.
// A row of five slot cells keeps the top-5 list sorted; each cell compares
// the new score against its own entry and shifts with its neighbors in the
// same cycle. The last word of a sample sets a pending request register,
// which then writes the result word and count into the result queue.
// A three-word result queue parts the two sides; when out_ch stalls the
// queue fills and in_ch.ready drops until room frees up.
// Reset (rst_n low, synchronous) clears the error count, the class counter,
// the queue and error_kind; no clearing pass is needed.

module topk_classification_error_counter (
  input  logic        clk,
  input  logic        rst_n,
  tkce_in_if.sink     in_ch,
  tkce_out_if.source  out_ch,
  tkce_cfg_if.sink    cfg_ch
);
  import tkce_pkg::*;

  logic                  kind_r;
  logic [CLASS_W-1:0]    class_cnt_r;
  logic [SCORE_BITS-1:0] best_key_r;
  logic [CLASS_W-1:0]    best_class_r;
  logic                  req_pend_r;
  logic                  req_kind_r;
  logic [CLASS_W-1:0]    req_label_r;
  res_req_t              req;
  logic                  room;
  logic                  accept;
  logic                  fresh;
  logic                  evict;
  logic [SCORE_BITS-1:0] new_key;
  cell_t                 new_item;
  cell_t                 cell_item [TOP_SLOTS];
  logic                  cell_less [TOP_SLOTS];

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = room;
  assign accept       = in_ch.valid & room;

  assign fresh   = (class_cnt_r == '0);
  assign evict   = (class_cnt_r >= CLASS_W'(TOP_SLOTS));
  assign new_key = {~in_ch.score[SCORE_BITS-1], in_ch.score[SCORE_BITS-2:0]};

  always_comb begin
    new_item.valid = 1'b1;
    new_item.key   = new_key;
    new_item.pos   = evict ? cell_item[0].pos : class_cnt_r[POS_W-1:0];
    new_item.cls   = class_cnt_r;
  end

  for (genvar i = 0; i < TOP_SLOTS; i++) begin : g_cell
    cell_t left_item;
    logic  left_less;
    cell_t right_item;
    logic  right_less;

    if (i == 0) begin : g_head
      assign left_item = new_item;
      assign left_less = 1'b1;
    end else begin : g_mid
      assign left_item = cell_item[i-1];
      assign left_less = cell_less[i-1];
    end

    if (i == TOP_SLOTS - 1) begin : g_tail
      assign right_item = new_item;
      assign right_less = 1'b0;
    end else begin : g_body
      assign right_item = cell_item[i+1];
      assign right_less = cell_less[i+1];
    end

    tkce_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .load       (accept),
      .fresh      (fresh),
      .evict      (evict),
      .new_item   (new_item),
      .left_item  (left_item),
      .left_less  (left_less),
      .right_item (right_item),
      .right_less (right_less),
      .item       (cell_item[i]),
      .less       (cell_less[i])
    );
  end

  always_ff @(posedge clk) begin
    if (accept && (fresh || new_key > best_key_r)) begin
      best_key_r   <= new_key;
      best_class_r <= class_cnt_r;
    end
    if (accept && in_ch.last) begin
      req_kind_r  <= kind_r;
      req_label_r <= in_ch.label;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_TOP1;
      class_cnt_r <= '0;
      req_pend_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        kind_r <= cfg_ch.error_kind;
      end
      req_pend_r <= accept & in_ch.last;
      if (accept) begin
        if (in_ch.last) begin
          class_cnt_r <= '0;
        end else if (class_cnt_r != CLASS_LAST) begin
          class_cnt_r <= class_cnt_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    req.pend       = req_pend_r;
    req.kind       = req_kind_r;
    req.label      = req_label_r;
    req.best_class = best_class_r;
  end

  tkce_result u_result (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .slots  (cell_item),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

/* rtl/tkce_cell.sv */
`timescale 1ns / 1ps

module tkce_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic            fresh,
  input  logic            evict,
  input  tkce_pkg::cell_t new_item,
  input  tkce_pkg::cell_t left_item,
  input  logic            left_less,
  input  tkce_pkg::cell_t right_item,
  input  logic            right_less,
  output tkce_pkg::cell_t item,
  output logic            less
);
  import tkce_pkg::*;

  cell_t state_r;
  cell_t state_nxt;
  cell_t view;

  assign item = state_r;

  // entries of the previous sample count as empty on the next sample's first score
  always_comb begin
    view       = state_r;
    view.valid = state_r.valid & ~fresh;
  end

  assign less = view.valid && ({view.key, view.pos} < {new_item.key, new_item.pos});

  // slots kept sorted by (score, position), smallest at the head
  always_comb begin
    if (evict) begin
      if (right_less) begin
        state_nxt = right_item;
      end else if (less) begin
        state_nxt = new_item;
      end else begin
        state_nxt = state_r;
      end
    end else begin
      if (less) begin
        state_nxt = state_r;
      end else if (left_less) begin
        state_nxt = new_item;
      end else begin
        state_nxt       = left_item;
        state_nxt.valid = left_item.valid & ~fresh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.valid <= 1'b0;
    end else if (load) begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/tkce_result.sv */
`timescale 1ns / 1ps

module tkce_result (
  input  logic              clk,
  input  logic              rst_n,
  input  tkce_pkg::res_req_t req,
  input  tkce_pkg::cell_t   slots [tkce_pkg::TOP_SLOTS],
  output logic              room,
  tkce_out_if.source        out_ch
);
  import tkce_pkg::*;

  logic [COUNT_W-1:0] miss_total_r;
  logic [COUNT_W-1:0] total_nxt;
  q_word_t            q_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W-1:0]  cnt_r;
  logic               hit5;
  logic               miss;
  logic               pop;
  logic               push;

  always_comb begin
    hit5 = 1'b0;
    for (int k = 0; k < TOP_SLOTS; k++) begin
      if (slots[k].valid && slots[k].cls == req.label) hit5 = 1'b1;
    end
  end

  assign miss = (req.kind == KIND_TOP5) ? ~hit5 : (req.best_class != req.label);
  assign total_nxt = (miss && miss_total_r != COUNT_MAX) ? miss_total_r + 1'b1
                                                         : miss_total_r;

  assign push = req.pend;
  assign pop  = out_ch.valid & out_ch.ready;
  assign room = ({1'b0, cnt_r} + {{QPTR_W{1'b0}}, req.pend}) < (QPTR_W + 1)'(QDEPTH);

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.miss        = q_r[rd_ptr_r].miss;
  assign out_ch.error_count = q_r[rd_ptr_r].count;
  assign out_ch.done_res    = 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{miss: miss, count: total_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_total_r <= '0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      if (push) begin
        miss_total_r <= total_nxt;
        wr_ptr_r     <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QPTR_W'(push) - QPTR_W'(pop);
    end
  end

endmodule
